// File: rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer: result
// kinds, controller states, command and status bundles, character codes.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // field widths
  localparam int COL_W      = 8;
  localparam int ROW_W      = 7;
  localparam int LINE_W     = 4;
  localparam int MASK_W     = 6;
  localparam int COLOUR_W   = 24;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CURS_COL_W = 9;
  localparam int TCOLS_W    = 9;
  localparam int TROWS_W    = 8;

  // font store
  localparam int FONT_DEPTH = 3072;
  localparam int FONT_AW    = 12;
  localparam int FADDR_W    = 13;

  // command codes on the result channel
  localparam logic [CMD_W-1:0] CMD_INVERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FG      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG      = 2'd3;

  // register reset values
  localparam logic [TCOLS_W-1:0]  RST_COLUMNS = 9'd80;
  localparam logic [TROWS_W-1:0]  RST_ROWS    = 8'd25;
  localparam logic [COLOUR_W-1:0] RST_FG      = 24'hFFFFFF;
  localparam logic [COLOUR_W-1:0] RST_BG      = 24'h000000;

  // control characters
  localparam logic [7:0] CH_BS        = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_PRINT_MIN = 8'd32;

  // request types
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_FONT = 1'b1;

  typedef enum logic [1:0] {
    K_INVERT,
    K_DRAW,
    K_SCROLL
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INV_OLD,
    S_DRAW,
    S_SCROLL,
    S_INV_NEW
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      load_char;
    logic      font_wr;
    logic      emit;
    res_kind_t kind;
    logic      last;
    logic      line_clr;
    logic      line_inc;
    logic      cursor_upd;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic line_last;
    logic is_print;
    logic need_scroll;
  } ctl_stat_t;

endpackage

// File: rtl/text_console_glyph_renderer_unit.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit
// Text console renderer: turns character bytes into frame-store line commands
// and loads its font store one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready): req_type selects a character request
//   (char_code) or a font write (font_index, font_byte). A font write
//   produces no result.
//   out channel (out_valid/out_ready): one frame-store command per cycle
//   unless the receiver stalls: GLYPH_HEIGHT inversions of the old cursor
//   cell, GLYPH_HEIGHT glyph rows for a printable code, an optional scroll,
//   then GLYPH_HEIGHT inversions of the new cursor cell; last marks the final
//   command of a character. A character yields 2*GLYPH_HEIGHT to
//   3*GLYPH_HEIGHT+1 commands, which the sequencer emits into a single result
//   register. A taken request first enters the old-cursor inversion state.
//   Reset clears the cursor to the top-left cell and restores the register
//   defaults; the font store holds no defined value until written. When the
//   receiver stalls the result register holds and the sequencer waits; a new
//   request is taken once the previous character has issued its final
//   command, even while that command still waits in the register.
//   cfg_we/cfg_index/cfg_data write the screen size and colours; the user
//   must write them only when idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit import tcgr_pkg::*; #(
  parameter int GLYPH_WIDTH  = 6,
  parameter int GLYPH_HEIGHT = 12,
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_ROWS     = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [7:0]            char_code,
  input  logic [11:0]           font_index,
  input  logic [7:0]            font_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CMD_W-1:0]      command,
  output logic [COL_W-1:0]      cell_column,
  output logic [ROW_W-1:0]      cell_row,
  output logic [LINE_W-1:0]     glyph_line,
  output logic [MASK_W-1:0]     pixel_mask,
  output logic [COLOUR_W-1:0]   on_colour,
  output logic [COLOUR_W-1:0]   off_colour,
  output logic                  last
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencer
  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  tcgr_datapath #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_code   (char_code),
    .font_index  (font_index),
    .font_byte   (font_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .command     (command),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .glyph_line  (glyph_line),
    .pixel_mask  (pixel_mask),
    .on_colour   (on_colour),
    .off_colour  (off_colour),
    .last        (last)
  );

endmodule

// File: rtl/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer of the renderer: takes requests, then steps through old cursor
// inversion, glyph drawing, scroll and new cursor inversion.
// ----------------------------------------------------------------------------
module tcgr_ctrl import tcgr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      req_type,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && req_type == REQ_CHAR) begin
          state_next = S_INV_OLD;
        end
      end
      S_INV_OLD: begin
        if (stat.out_free && stat.line_last) begin
          if (stat.is_print) begin
            state_next = S_DRAW;
          end else if (stat.need_scroll) begin
            state_next = S_SCROLL;
          end else begin
            state_next = S_INV_NEW;
          end
        end
      end
      S_DRAW: begin
        if (stat.out_free && stat.line_last) begin
          state_next = stat.need_scroll ? S_SCROLL : S_INV_NEW;
        end
      end
      S_SCROLL: begin
        if (stat.out_free) begin
          state_next = S_INV_NEW;
        end
      end
      S_INV_NEW: begin
        if (stat.out_free && stat.line_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.kind       = K_INVERT;
    unique case (state)
      S_IDLE: begin
        // no request is taken while reset is held
        in_ready      = !rst;
        cmd.load_char = !rst && in_valid && req_type == REQ_CHAR;
        cmd.font_wr   = !rst && in_valid && req_type == REQ_FONT;
        cmd.line_clr  = 1'b1;
      end
      S_INV_OLD: begin
        cmd.kind = K_INVERT;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.line_last) begin
            cmd.line_clr   = 1'b1;
            cmd.cursor_upd = !stat.is_print && !stat.need_scroll;
          end else begin
            cmd.line_inc = 1'b1;
          end
        end
      end
      S_DRAW: begin
        cmd.kind = K_DRAW;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.line_last) begin
            cmd.line_clr   = 1'b1;
            cmd.cursor_upd = !stat.need_scroll;
          end else begin
            cmd.line_inc = 1'b1;
          end
        end
      end
      S_SCROLL: begin
        cmd.kind = K_SCROLL;
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.line_clr   = 1'b1;
          cmd.cursor_upd = 1'b1;
        end
      end
      S_INV_NEW: begin
        cmd.kind = K_INVERT;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = stat.line_last;
          if (stat.line_last) begin
            cmd.line_clr = 1'b1;
          end else begin
            cmd.line_inc = 1'b1;
          end
        end
      end
      default: begin
        cmd.kind = K_INVERT;
      end
    endcase
  end

endmodule

// File: rtl/tcgr_datapath.sv
// ----------------------------------------------------------------------------
// tcgr_datapath
// Configuration registers, cursor, font store, cursor move logic and the
// result register of the renderer.
// ----------------------------------------------------------------------------
module tcgr_datapath import tcgr_pkg::*; #(
  parameter int GLYPH_WIDTH  = 6,
  parameter int GLYPH_HEIGHT = 12,
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_ROWS     = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            char_code,
  input  logic [11:0]           font_index,
  input  logic [7:0]            font_byte,
  input  ctl_cmd_t              cmd,
  output ctl_stat_t             stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [CMD_W-1:0]      command,
  output logic [COL_W-1:0]      cell_column,
  output logic [ROW_W-1:0]      cell_row,
  output logic [LINE_W-1:0]     glyph_line,
  output logic [MASK_W-1:0]     pixel_mask,
  output logic [COLOUR_W-1:0]   on_colour,
  output logic [COLOUR_W-1:0]   off_colour,
  output logic                  last
);

  localparam logic [LINE_W-1:0]  LINE_MAX = LINE_W'(GLYPH_HEIGHT - 1);
  localparam logic [TCOLS_W-1:0] COLS_MAX = TCOLS_W'(MAX_COLUMNS);
  localparam logic [TROWS_W-1:0] ROWS_MAX = TROWS_W'(MAX_ROWS);

  logic [TCOLS_W-1:0]    text_columns;
  logic [TROWS_W-1:0]    text_rows;
  logic [COLOUR_W-1:0]   fg_colour;
  logic [COLOUR_W-1:0]   bg_colour;
  logic [CURS_COL_W-1:0] cursor_column;
  logic [ROW_W-1:0]      cursor_row;
  logic [7:0]            char_q;
  logic [LINE_W-1:0]     line;
  logic [LINE_W-1:0]     line_next;
  logic [7:0]            font_mem [FONT_DEPTH];
  logic [7:0]            rd_data;
  logic                  rd_oob;
  logic [FADDR_W-1:0]    rd_addr;
  logic                  rd_in_range;
  logic                  wr_in_range;
  logic [TCOLS_W-1:0]    cols_eff;
  logic [TROWS_W-1:0]    rows_eff;
  logic [9:0]            mv_col;
  logic [TROWS_W-1:0]    mv_row;
  logic [9:0]            wr_col;
  logic [TROWS_W-1:0]    wr_row;
  logic                  scroll;
  logic [MASK_W-1:0]     full_mask;
  logic [MASK_W-1:0]     glyph_mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= RST_COLUMNS;
      text_rows    <= RST_ROWS;
      fg_colour    <= RST_FG;
      bg_colour    <= RST_BG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS: text_columns <= cfg_data[TCOLS_W-1:0];
        REG_ROWS:    text_rows    <= cfg_data[TROWS_W-1:0];
        REG_FG:      fg_colour    <= cfg_data;
        REG_BG:      bg_colour    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // clamped screen size
  always_comb begin
    cols_eff = text_columns;
    if (cols_eff == '0) cols_eff = TCOLS_W'(1);
    if (cols_eff > COLS_MAX) cols_eff = COLS_MAX;
    rows_eff = text_rows;
    if (rows_eff == '0) rows_eff = TROWS_W'(1);
    if (rows_eff > ROWS_MAX) rows_eff = ROWS_MAX;
  end

  // character register
  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_q <= char_code;
    end
  end

  // glyph line counter
  always_comb begin
    line_next = line;
    if (cmd.line_clr) begin
      line_next = '0;
    end else if (cmd.line_inc) begin
      line_next = line + LINE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line <= '0;
    end else begin
      line <= line_next;
    end
  end

  // font store; the read address uses the next line count, so the read data matches the line counter
  assign rd_addr     = FADDR_W'(char_q) * FADDR_W'(GLYPH_HEIGHT) + FADDR_W'(line_next);
  assign rd_in_range = rd_addr < FADDR_W'(FONT_DEPTH);
  assign wr_in_range = font_index < FONT_AW'(FONT_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.font_wr && wr_in_range) begin
      font_mem[font_index] <= font_byte;
    end
    rd_data <= font_mem[rd_addr[FONT_AW-1:0]];
    rd_oob  <= !rd_in_range;
  end

  // cursor move for the current character
  always_comb begin
    mv_col = {1'b0, cursor_column};
    mv_row = {1'b0, cursor_row};
    if (char_q == CH_BS) begin
      if (cursor_column != '0) begin
        mv_col = {1'b0, cursor_column} - 10'd1;
      end else if (cursor_row != '0) begin
        mv_col = {1'b0, cols_eff} - 10'd1;
        mv_row = {1'b0, cursor_row} - TROWS_W'(1);
      end
    end else if (char_q == CH_CR) begin
      mv_col = '0;
    end else if (char_q == CH_LF) begin
      mv_col = '0;
      mv_row = {1'b0, cursor_row} + TROWS_W'(1);
    end else if (char_q == CH_TAB) begin
      mv_col = {mv_col[9:3] + 7'd1, 3'b000};
    end else if (char_q >= CH_PRINT_MIN) begin
      mv_col = mv_col + 10'd1;
    end
  end

  // wrap at the last column, scroll past the bottom row
  always_comb begin
    wr_col = mv_col;
    wr_row = mv_row;
    if (mv_col >= {1'b0, cols_eff}) begin
      wr_col = '0;
      wr_row = mv_row + TROWS_W'(1);
    end
    scroll = wr_row >= rows_eff;
    if (scroll) begin
      wr_row = rows_eff - TROWS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (cmd.cursor_upd) begin
      cursor_column <= wr_col[CURS_COL_W-1:0];
      cursor_row    <= wr_row[ROW_W-1:0];
    end
  end

  // pixel masks
  always_comb begin
    full_mask  = '0;
    glyph_mask = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (j < GLYPH_WIDTH) begin
        full_mask[MASK_W-1-j]  = 1'b1;
        glyph_mask[MASK_W-1-j] = rd_data[7-j] && !rd_oob;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.last;
      case (cmd.kind)
        K_DRAW: begin
          command     <= CMD_DRAW;
          cell_column <= cursor_column[COL_W-1:0];
          cell_row    <= cursor_row;
          glyph_line  <= line;
          pixel_mask  <= glyph_mask;
          on_colour   <= fg_colour;
          off_colour  <= bg_colour;
        end
        K_SCROLL: begin
          command     <= CMD_SCROLL;
          cell_column <= '0;
          cell_row    <= ROW_W'(rows_eff - TROWS_W'(1));
          glyph_line  <= '0;
          pixel_mask  <= '0;
          on_colour   <= '0;
          off_colour  <= bg_colour;
        end
        default: begin
          command     <= CMD_INVERT;
          cell_column <= cursor_column[COL_W-1:0];
          cell_row    <= cursor_row;
          glyph_line  <= line;
          pixel_mask  <= full_mask;
          on_colour   <= '0;
          off_colour  <= '0;
        end
      endcase
    end
  end

  // status to the sequencer
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.line_last   = line == LINE_MAX;
  assign stat.is_print    = char_q >= CH_PRINT_MIN;
  assign stat.need_scroll = scroll;

endmodule

// File: tb/sv/text_console_glyph_renderer_checker.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_checker
// Watches the register port and both channels of the glyph renderer.
// It keeps its own copy of the screen size, colours, cursor and font store,
// works out the frame-store commands for every character request it sees,
// and compares each command that leaves the block, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_glyph_renderer_checker import tcgr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  req_type,
  input  logic [7:0]            char_code,
  input  logic [11:0]           font_index,
  input  logic [7:0]            font_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [COL_W-1:0]      cell_column,
  input  logic [ROW_W-1:0]      cell_row,
  input  logic [LINE_W-1:0]     glyph_line,
  input  logic [MASK_W-1:0]     pixel_mask,
  input  logic [COLOUR_W-1:0]   on_colour,
  input  logic [COLOUR_W-1:0]   off_colour,
  input  logic                  last,
  output int                    fail_count,
  output int                    cmds_pending,
  output int                    cmds_checked
);

  localparam int GLYPH_W  = 6;
  localparam int GLYPH_H  = 12;
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 128;
  // all six pixels of a cell line
  localparam logic [MASK_W-1:0] FULL_MASK = 6'h3F;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [LINE_W-1:0]   line;
    logic [MASK_W-1:0]   mask;
    logic [COLOUR_W-1:0] on;
    logic [COLOUR_W-1:0] off;
    logic                fin;
  } frame_cmd_t;

  frame_cmd_t expected_cmds[$];
  frame_cmd_t oldest_cmd;

  // shadow of the block's registers and state
  logic [7:0]          glyph_rom [0:FONT_DEPTH-1];
  logic [TCOLS_W-1:0]  columns_reg;
  logic [TROWS_W-1:0]  rows_reg;
  logic [COLOUR_W-1:0] fg_reg;
  logic [COLOUR_W-1:0] bg_reg;
  logic [8:0]          cur_col;
  logic [6:0]          cur_row;

  initial begin
    fail_count   = 0;
    cmds_pending = 0;
    cmds_checked = 0;
  end

  function automatic frame_cmd_t make_cmd(input logic [CMD_W-1:0] cmd, input int col,
                                          input int row, input int line,
                                          input logic [MASK_W-1:0] mask,
                                          input logic [COLOUR_W-1:0] on,
                                          input logic [COLOUR_W-1:0] off, input logic fin);
    frame_cmd_t c;
    c.cmd  = cmd;
    c.col  = col[COL_W-1:0];
    c.row  = row[ROW_W-1:0];
    c.line = line[LINE_W-1:0];
    c.mask = mask;
    c.on   = on;
    c.off  = off;
    c.fin  = fin;
    return c;
  endfunction

  // every line of the cursor cell gets inverted
  task automatic invert_cursor(input logic closing);
    int i;
    for (i = 0; i < GLYPH_H; i++)
      expected_cmds.push_back(make_cmd(CMD_INVERT, cur_col, cur_row, i, FULL_MASK, '0, '0,
                                       closing && (i == GLYPH_H - 1)));
  endtask

  task automatic render_char(input logic [7:0] ch);
    int ncols, nrows, c, r, i, j, addr;
    logic [7:0] bits;
    logic [MASK_W-1:0] m;
    // out-of-range sizes are clamped
    ncols = (columns_reg == 0) ? 1 : ((columns_reg > MAX_COLS) ? MAX_COLS : columns_reg);
    nrows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    invert_cursor(1'b0);
    c = cur_col;
    r = cur_row;
    if (ch == CH_BS) begin
      // backspace climbs to the end of the line above, stuck at top-left
      if (c != 0) begin
        c--;
      end else if (r != 0) begin
        c = ncols - 1;
        r--;
      end
    end else if (ch == CH_CR) begin
      c = 0;
    end else if (ch == CH_LF) begin
      c = 0;
      r++;
    end else if (ch == CH_TAB) begin
      c = c + 8 - (c % 8);
    end else if (ch >= CH_PRINT_MIN) begin
      for (i = 0; i < GLYPH_H; i++) begin
        addr = ch;
        addr = addr * GLYPH_H + i;
        bits = glyph_rom[addr];
        m = '0;
        for (j = 0; j < GLYPH_W; j++)
          if (bits[7-j]) m[5-j] = 1'b1;
        expected_cmds.push_back(make_cmd(CMD_DRAW, c, r, i, m, fg_reg, bg_reg, 1'b0));
      end
      c++;
    end
    // wrap, then at most one scroll
    if (c >= ncols) begin
      c = 0;
      r++;
    end
    if (r >= nrows) begin
      expected_cmds.push_back(make_cmd(CMD_SCROLL, 0, nrows - 1, 0, '0, '0, bg_reg, 1'b0));
      r = nrows - 1;
    end
    cur_col = c[8:0];
    cur_row = r[6:0];
    invert_cursor(1'b1);
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      columns_reg = RST_COLUMNS;
      rows_reg    = RST_ROWS;
      fg_reg      = RST_FG;
      bg_reg      = RST_BG;
      cur_col     = '0;
      cur_row     = '0;
      expected_cmds.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS: columns_reg = cfg_data[TCOLS_W-1:0];
          REG_ROWS:    rows_reg    = cfg_data[TROWS_W-1:0];
          REG_FG:      fg_reg      = cfg_data;
          REG_BG:      bg_reg      = cfg_data;
          default: ;
        endcase
      end
      // outgoing command against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected command %0d at column %0d row %0d line %0d",
                 command, cell_column, cell_row, glyph_line);
          fail_count++;
        end else begin
          oldest_cmd = expected_cmds.pop_front();
          check_field("command", oldest_cmd.cmd, command);
          check_field("cell_column", oldest_cmd.col, cell_column);
          check_field("cell_row", oldest_cmd.row, cell_row);
          check_field("glyph_line", oldest_cmd.line, glyph_line);
          check_field("pixel_mask", oldest_cmd.mask, pixel_mask);
          check_field("on_colour", oldest_cmd.on, on_colour);
          check_field("off_colour", oldest_cmd.off, off_colour);
          check_field("last", oldest_cmd.fin, last);
          cmds_checked++;
        end
      end
      // incoming request: font write or character
      if (in_valid && in_ready) begin
        if (req_type == REQ_FONT) begin
          if (font_index < FONT_DEPTH) glyph_rom[font_index] = font_byte;
        end else begin
          render_char(char_code);
        end
      end
    end
    cmds_pending <= expected_cmds.size();
  end

endmodule

// File: tb/sv/text_console_glyph_renderer_unit_tb.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit_tb
// Drives character and font-write requests into the glyph renderer under
// random stalls on both channels, walks through several screen sizes and
// colour settings, and leaves all checking of the frame-store commands to
// the checker beside the block. Directed cursor moves come first, then
// random text with glyphs loaded on demand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_glyph_renderer_unit_tb import tcgr_pkg::*;;

  localparam int GLYPH_H        = 12;
  localparam int TOTAL_ITEMS    = 210;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_CHAR;
  logic [7:0]            char_code = '0;
  logic [11:0]           font_index = '0;
  logic [7:0]            font_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CMD_W-1:0]      command;
  logic [COL_W-1:0]      cell_column;
  logic [ROW_W-1:0]      cell_row;
  logic [LINE_W-1:0]     glyph_line;
  logic [MASK_W-1:0]     pixel_mask;
  logic [COLOUR_W-1:0]   on_colour;
  logic [COLOUR_W-1:0]   off_colour;
  logic                  last;
  int                    fail_count;
  int                    cmds_pending;
  int                    cmds_checked;

  // stimulus bookkeeping
  bit         font_written [0:FONT_DEPTH-1];
  logic [7:0] loaded_chars[$];
  bit         calm = 1'b0;
  int         chars_sent = 0;
  int         fonts_sent = 0;
  int         settings_used = 0;
  int         stall_cycles = 0;

  text_console_glyph_renderer_unit dut (.*);

  text_console_glyph_renderer_checker checker_i (.*);

  always #6 clk = ~clk;

  // watchdog on cycles where no request moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random stall before every command
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // one request on the input channel; starts and ends at a falling edge
  task automatic send_request(input logic typ, input logic [7:0] ch,
                              input logic [11:0] idx, input logic [7:0] fb);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= typ;
    char_code  <= ch;
    font_index <= idx;
    font_byte  <= fb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_font(input logic [11:0] idx, input logic [7:0] fb);
    send_request(REQ_FONT, 8'($urandom()), idx, fb);
    if (idx < FONT_DEPTH) font_written[idx] = 1'b1;
    fonts_sent++;
  endtask

  // fill the missing lines of a glyph: 0 random, 1 blank, 2 solid
  task automatic load_glyph(input logic [7:0] ch, input int style);
    int i, addr;
    logic [7:0] b;
    for (i = 0; i < GLYPH_H; i++) begin
      addr = ch;
      addr = addr * GLYPH_H + i;
      if (!font_written[addr]) begin
        case (style)
          1:       b = 8'h00;
          2:       b = 8'hFF;
          default: begin
            b = 8'($urandom());
            if ($urandom_range(0, 7) == 0) b = 8'hFF;
            else if ($urandom_range(0, 7) == 0) b = 8'h00;
          end
        endcase
        write_font(addr[11:0], b);
      end
    end
    loaded_chars.push_back(ch);
  endtask

  function automatic bit glyph_ready(input logic [7:0] ch);
    int i, addr;
    for (i = 0; i < GLYPH_H; i++) begin
      addr = ch;
      addr = addr * GLYPH_H + i;
      if (!font_written[addr]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // printable codes never read an unwritten font line
  task automatic send_char(input logic [7:0] ch);
    if (ch >= CH_PRINT_MIN && !glyph_ready(ch)) load_glyph(ch, 0);
    send_request(REQ_CHAR, ch, 12'($urandom()), 8'($urandom()));
    chars_sent++;
  endtask

  // registers change only with nothing in flight
  task automatic configure(input logic [23:0] cols_word, input logic [23:0] rows_word,
                           input logic [23:0] fg, input logic [23:0] bg);
    in_valid <= 1'b0;
    while (cmds_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= cols_word;
    @(negedge clk);
    cfg_index <= REG_ROWS;
    cfg_data  <= rows_word;
    @(negedge clk);
    cfg_index <= REG_FG;
    cfg_data  <= fg;
    @(negedge clk);
    cfg_index <= REG_BG;
    cfg_data  <= bg;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [23:0] pick_colour();
    case ($urandom_range(0, 3))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_item();
    int pick;
    logic [7:0] ch;
    pick = $urandom_range(0, 19);
    if (pick <= 7) begin
      if (loaded_chars.size() > 0 && $urandom_range(0, 3) != 0)
        ch = loaded_chars[$urandom_range(0, loaded_chars.size() - 1)];
      else
        ch = 8'($urandom_range(32, 255));
      send_char(ch);
    end else if (pick <= 9) begin
      send_char(CH_LF);
    end else if (pick <= 11) begin
      send_char(CH_CR);
    end else if (pick <= 13) begin
      send_char(CH_TAB);
    end else if (pick <= 15) begin
      send_char(CH_BS);
    end else if (pick == 16) begin
      send_char(8'($urandom_range(0, 31)));
    end else begin
      // font write anywhere, beyond the store included
      write_font(12'($urandom_range(0, 4095)), 8'($urandom()));
    end
  endtask

  initial begin
    logic [23:0] cols_word, rows_word;
    int n;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: glyphs, writes beyond the store, cursor moves at reset size
    load_glyph(8'd65, 0);
    load_glyph(8'd255, 2);
    load_glyph(CH_PRINT_MIN, 1);
    write_font(12'd4095, 8'hA5);
    write_font(12'd3072, 8'h5A);
    write_font(12'd0, 8'hFF);
    send_char(8'd65);
    send_char(8'd255);
    send_char(CH_PRINT_MIN);
    repeat (4) send_char(CH_BS);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_LF);
    send_char(8'd0);
    send_char(8'd31);
    send_char(8'd27);
    repeat (3) send_char(CH_TAB);

    // shrink below the cursor: zero columns, two rows
    configure(24'hFFFE00, 24'h5A5A02, 24'h000000, 24'hFFFFFF);
    send_char(8'd65);
    send_char(CH_BS);
    send_char(CH_LF);

    // oversized counts clamp to the maximum screen
    configure(24'h0001FF, 24'h0000FF, 24'($urandom()), 24'($urandom()));
    send_char(CH_BS);
    send_char(8'd65);

    // single-cell screen
    configure(24'h000001, 24'h000001, 24'hFFFFFF, 24'h000000);
    send_char(CH_LF);
    send_char(8'd255);

    // random phases, each with its own screen settings
    while (chars_sent + fonts_sent < TOTAL_ITEMS) begin
      cols_word = 24'($urandom());
      case ($urandom_range(0, 6))
        0: cols_word[8:0] = 9'd1;
        1: cols_word[8:0] = 9'd256;
        2: cols_word[8:0] = 9'd0;
        3: cols_word[8:0] = 9'($urandom_range(257, 511));
        4: cols_word[8:0] = 9'd80;
        5: cols_word[8:0] = 9'($urandom_range(2, 12));
        default: cols_word[8:0] = 9'($urandom_range(1, 256));
      endcase
      rows_word = 24'($urandom());
      case ($urandom_range(0, 6))
        0: rows_word[7:0] = 8'd1;
        1: rows_word[7:0] = 8'd128;
        2: rows_word[7:0] = 8'd0;
        3: rows_word[7:0] = 8'($urandom_range(129, 255));
        4: rows_word[7:0] = 8'd25;
        5: rows_word[7:0] = 8'($urandom_range(2, 6));
        default: rows_word[7:0] = 8'($urandom_range(1, 128));
      endcase
      configure(cols_word, rows_word, pick_colour(), pick_colour());
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 35);
      repeat (n) begin
        if (chars_sent + fonts_sent < TOTAL_ITEMS) random_item();
      end
    end

    // drain and give stray commands a chance to show up
    in_valid <= 1'b0;
    calm = 1'b0;
    while (cmds_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (cmds_pending != 0) $error("%0d expected commands never arrived", cmds_pending);

    $display("sent %0d characters and %0d font writes over %0d screen settings",
             chars_sent, fonts_sent, settings_used);
    $display("compared %0d frame-store commands", cmds_checked);
    if (fail_count == 0 && cmds_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
